/* src/dqs_pkg.sv */
// Shared opcodes, status codes and transfer types of the deque-with-search block.
package dqs_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned StW  = 2;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 5;

  localparam logic [OpW-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_INS_REAR  = 3'd1;
  localparam logic [OpW-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OpW-1:0] OP_REM_REAR  = 3'd3;
  localparam logic [OpW-1:0] OP_SEARCH    = 3'd4;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StW-1:0] ST_FULL  = 2'd2;
  localparam logic [StW-1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic signed [ValW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic signed [ValW-1:0] removed_value;
    logic [PosW-1:0]        found_position;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INSERT,
    CMD_REM_READ,
    CMD_REM_DONE,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_HIT
  } cmd_e;

  // CMD_NONE with fail set closes the item with the given status and zero fields.
  typedef struct packed {
    cmd_e           cmd;
    logic           fail;
    logic [StW-1:0] status;
  } ctl_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           full;
    logic           empty;
    logic           hit;
    logic           last;
  } sts_t;

endpackage

/* src/dqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/dqs_datapath.sv */
// Datapath: ring pointers, occupancy, scan counter, entry RAM and result register.
module dqs_datapath #(
  parameter int unsigned Capacity = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dqs_pkg::req_t req_i,
  input  dqs_pkg::ctl_t ctl_i,
  output dqs_pkg::sts_t sts_o,
  output dqs_pkg::rsp_t rsp_o
);
  import dqs_pkg::*;

  localparam int unsigned IW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned SW = CW + 1;

  req_t          req_q;
  rsp_t          rsp_q, rsp_d;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] scan_q, scan_d;

  logic [CW-1:0]   off;
  logic [SW-1:0]   sum;
  logic [IW-1:0]   slot;
  logic [IW-1:0]   scan_nxt;
  logic            wr_en, rd_en;
  logic [IW-1:0]   rd_addr;
  logic [ValW-1:0] rd_data;
  logic [31:0]     pos_full;

  // Ring offset chosen by the current command and opcode.
  always_comb begin
    off = '0;
    unique case (req_q.opcode)
      OP_INS_FRONT: off = CW'(Capacity - 1);
      OP_INS_REAR:  off = occ_q;
      OP_REM_FRONT: off = (ctl_i.cmd == CMD_REM_DONE) ? CW'(1) : '0;
      OP_REM_REAR:  off = occ_q - CW'(1);
      default:      off = '0;
    endcase
  end

  // Wrap front + offset into the ring: the sum stays below twice the capacity.
  always_comb begin
    sum = SW'(front_q) + SW'(off);
    if (sum >= SW'(Capacity)) begin
      sum = sum - SW'(Capacity);
    end
    slot = sum[IW-1:0];
  end

  assign scan_nxt = (SW'(scan_q) == SW'(Capacity - 1)) ? '0 : scan_q + IW'(1);

  always_comb begin
    wr_en   = (ctl_i.cmd == CMD_INSERT);
    rd_en   = 1'b0;
    rd_addr = slot;
    unique case (ctl_i.cmd)
      CMD_REM_READ: begin
        rd_en = 1'b1;
      end
      CMD_SCAN_START: begin
        rd_en   = 1'b1;
        rd_addr = front_q;
      end
      CMD_SCAN_STEP: begin
        rd_en   = 1'b1;
        rd_addr = scan_nxt;
      end
      default: ;
    endcase
  end

  dqs_ram #(
    .Width (ValW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot),
    .wr_data_i (req_q.item_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign pos_full = 32'(idx_q) + 32'd1;

  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    idx_d   = idx_q;
    scan_d  = scan_q;
    rsp_d   = rsp_q;
    unique case (ctl_i.cmd)
      CMD_INSERT: begin
        if (req_q.opcode == OP_INS_FRONT) begin
          front_d = slot;
        end
        occ_d = occ_q + CW'(1);
        rsp_d = '{status: ST_OK, removed_value: '0, found_position: '0};
      end
      CMD_REM_DONE: begin
        if (req_q.opcode == OP_REM_FRONT) begin
          front_d = slot;
        end
        occ_d = occ_q - CW'(1);
        rsp_d = '{status: ST_OK, removed_value: rd_data, found_position: '0};
      end
      CMD_SCAN_START: begin
        idx_d  = '0;
        scan_d = front_q;
      end
      CMD_SCAN_STEP: begin
        idx_d  = idx_q + CW'(1);
        scan_d = scan_nxt;
      end
      CMD_HIT: begin
        rsp_d = '{status: ST_OK, removed_value: '0, found_position: pos_full[PosW-1:0]};
      end
      default: begin
        if (ctl_i.fail) begin
          rsp_d = '{status: ctl_i.status, removed_value: '0, found_position: '0};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
    end else begin
      front_q <= front_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CMD_LOAD) begin
      req_q <= req_i;
    end
    idx_q  <= idx_d;
    scan_q <= scan_d;
    rsp_q  <= rsp_d;
  end

  assign sts_o.op    = req_q.opcode;
  assign sts_o.full  = (SW'(occ_q) == SW'(Capacity));
  assign sts_o.empty = (occ_q == '0);
  assign sts_o.hit   = (rd_data == req_q.item_value);
  assign sts_o.last  = ((SW'(idx_q) + SW'(1)) == SW'(occ_q));

  assign rsp_o = rsp_q;

endmodule

/* src/dqs_ctrl.sv */
// Controller: sequences accept, execute, removal read and search scan.
module dqs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dqs_pkg::sts_t sts_i,
  output dqs_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);
  import dqs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REM,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ctl_o   = '{cmd: CMD_NONE, fail: 1'b0, status: ST_OK};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.cmd = CMD_LOAD;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        unique case (sts_i.op)
          OP_INS_FRONT, OP_INS_REAR: begin
            if (sts_i.full) begin
              ctl_o = '{cmd: CMD_NONE, fail: 1'b1, status: ST_FULL};
            end else begin
              ctl_o.cmd = CMD_INSERT;
            end
          end
          OP_REM_FRONT, OP_REM_REAR: begin
            if (sts_i.empty) begin
              ctl_o = '{cmd: CMD_NONE, fail: 1'b1, status: ST_EMPTY};
            end else begin
              ctl_o.cmd = CMD_REM_READ;
              state_d   = S_REM;
              done_d    = 1'b0;
            end
          end
          OP_SEARCH: begin
            if (sts_i.empty) begin
              ctl_o = '{cmd: CMD_NONE, fail: 1'b1, status: ST_EMPTY};
            end else begin
              ctl_o.cmd = CMD_SCAN_START;
              state_d   = S_SCAN;
              done_d    = 1'b0;
            end
          end
          default: begin
            // Unused opcodes: report ok with zero fields, change nothing.
            ctl_o = '{cmd: CMD_NONE, fail: 1'b1, status: ST_OK};
          end
        endcase
      end
      S_REM: begin
        ctl_o.cmd = CMD_REM_DONE;
        state_d   = S_IDLE;
        done_d    = 1'b1;
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          ctl_o.cmd = CMD_HIT;
          state_d   = S_IDLE;
          done_d    = 1'b1;
        end else if (sts_i.last) begin
          ctl_o   = '{cmd: CMD_NONE, fail: 1'b1, status: ST_MISS};
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          ctl_o.cmd = CMD_SCAN_STEP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

/* src/deque_with_search_core.sv */
// Top level of the bounded double-ended queue with linear search.
//
// A bounded deque of signed 32-bit items kept in a ring buffer of CAPACITY
// entries. A command transfer happens at a rising edge with start_i high and
// busy_o low; its opcode inserts at the front or rear, removes from the front
// or rear, or searches for item_value. Every command gives exactly one result
// on rsp_o, valid for the single cycle in which done_o is high; the receiver
// cannot stall, so capture it then. An insert, a failed command or an unused
// opcode finishes in the execute state; a removal adds one registered read of
// the entry RAM, and a search then compares k entries, k up to the occupancy.
// The search rate is set by the single RAM read port, which the scan walks
// one entry per cycle from the front. done_o rises in the cycle busy_o falls,
// so a new command may be started while the result is on the ports. The
// position field wraps to 5 bits if CAPACITY exceeds 31.
module deque_with_search_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dqs_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output dqs_pkg::rsp_t rsp_o
);
  import dqs_pkg::*;

  ctl_t ctl;  // commands from controller to datapath
  sts_t sts;  // status back to the controller

  // Sequence each command: accept, execute, then read or scan as needed.
  dqs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Hold pointers, entries and the result register.
  dqs_datapath #(
    .Capacity (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

/* verif/deque_with_search_core_tb.sv */
// Self-checking testbench for the deque core: directed rows, then random traffic vs. a predictor.
module deque_with_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqs_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned PHASES       = 4;
  // Slowest legal run: ~1300 transfers, each at most as long as a full search, plus sender gaps.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Longest command (full search) plus margin, waited out before the verdict.
  localparam int unsigned TAIL_CYCLES  = 2 * (DEPTH + 2);

  // Opcodes the block ignores.
  localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    req_t cmd;
    rsp_t rsp;
  } outcome_t;

  typedef struct {
    req_t        cmd;
    int unsigned reps;
    bit          typed;
    rsp_t        want;
  } stim_row_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  // Predictor state: ring of entries, front slot and fill level.
  logic [ValW-1:0] dq_store [DEPTH];
  int unsigned     dq_front = 0;
  int unsigned     dq_count = 0;

  outcome_t    owed_q [$];
  stim_row_t   stim_rows [$];
  int unsigned idle_pct    = 0;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  deque_with_search_core #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run: a missing result or a stuck busy ends up here.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, owed_q.size());
      $display("** deque_with_search_core: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned slot_of(int unsigned ofs);
    return (dq_front + ofs) % DEPTH;
  endfunction

  // Apply one command to the predictor and return the result it must produce.
  function automatic rsp_t apply_cmd(req_t cmd);
    rsp_t r;
    int unsigned idx;
    r = '0;
    r.status = ST_OK;
    case (cmd.opcode)
      OP_INS_FRONT: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_front = slot_of(DEPTH - 1);
          dq_store[dq_front] = cmd.item_value;
          dq_count++;
        end
      end
      OP_INS_REAR: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_store[slot_of(dq_count)] = cmd.item_value;
          dq_count++;
        end
      end
      OP_REM_FRONT: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_value = dq_store[slot_of(0)];
          dq_front = slot_of(1);
          dq_count--;
        end
      end
      OP_REM_REAR: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_value = dq_store[slot_of(dq_count - 1)];
          dq_count--;
        end
      end
      OP_SEARCH: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Scan from the front; first match wins, otherwise a miss.
          r.status = ST_MISS;
          for (idx = 0; idx < dq_count; idx++) begin
            if (dq_store[slot_of(idx)] == cmd.item_value) begin
              r.status = ST_OK;
              r.found_position = PosW'(idx + 1);
              break;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [ValW-1:0] random_value();
    logic [ValW-1:0] v;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0000;
        endcase
      end
      // Small pool so duplicates pile up and first-match ordering matters.
      1:       v = $urandom_range(7);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Draw a random command; the fill flag tilts the mix toward inserts or removals.
  function automatic req_t random_cmd(bit filling);
    req_t        c;
    int unsigned roll;
    int unsigned ins_w;
    int unsigned rem_w;
    ins_w = filling ? 55 : 20;
    rem_w = filling ? 20 : 55;
    roll = $urandom_range(99);
    c.item_value = random_value();
    if (roll < 3) begin
      c.opcode = OpW'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end else if (roll < 3 + ins_w) begin
      c.opcode = $urandom_range(1) ? OP_INS_FRONT : OP_INS_REAR;
    end else if (roll < 3 + ins_w + rem_w) begin
      c.opcode = $urandom_range(1) ? OP_REM_FRONT : OP_REM_REAR;
    end else begin
      c.opcode = OP_SEARCH;
      // Aim most searches at a held entry so hits land at every depth.
      if (dq_count != 0 && $urandom_range(99) < 60) begin
        c.item_value = dq_store[slot_of($urandom_range(dq_count - 1))];
      end
    end
    return c;
  endfunction

  function automatic void add_row(logic [OpW-1:0] op, logic [ValW-1:0] val,
                                  int unsigned reps, bit typed, logic [StW-1:0] st,
                                  logic [ValW-1:0] rem, logic [PosW-1:0] pos);
    stim_row_t row;
    row.cmd.opcode             = op;
    row.cmd.item_value         = val;
    row.reps                   = reps;
    row.typed                  = typed;
    row.want.status            = st;
    row.want.removed_value     = rem;
    row.want.found_position    = pos;
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, req_t cmd, logic [ValW-1:0] got,
                                 logic [ValW-1:0] want);
    $display("%0t: %s mismatch (op %0d value %h): got %h want %h",
             $time, what, cmd.opcode, cmd.item_value, got, want);
    err_count++;
  endtask

  // Drive one command and hold it until the transfer happens. Called at a clock
  // edge, so start_i gets one nonblocking update per edge at most.
  task automatic issue_cmd(req_t cmd, bit typed, rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= cmd;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    // Transfer taken at this edge: advance the predictor and queue the result.
    predicted = apply_cmd(cmd);
    owed_q.push_back('{cmd: cmd, rsp: typed ? want : predicted});
  endtask

  // Hold off the sender until every outstanding result has arrived.
  task automatic drain_results();
    start_i <= 1'b0;
    while (owed_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Capture each result in its single strobe cycle and match it to the oldest command.
  always @(posedge clk_i) begin
    outcome_t due;
    if (rst_ni && done_o) begin
      if (owed_q.size() == 0) begin
        report_mismatch("unrequested result", '0, ValW'(rsp_o.status), '0);
      end else begin
        due = owed_q.pop_front();
        if (rsp_o.status !== due.rsp.status)
          report_mismatch("status", due.cmd, ValW'(rsp_o.status), ValW'(due.rsp.status));
        if (rsp_o.removed_value !== due.rsp.removed_value)
          report_mismatch("removed_value", due.cmd, rsp_o.removed_value,
                          due.rsp.removed_value);
        if (rsp_o.found_position !== due.rsp.found_position)
          report_mismatch("found_position", due.cmd, ValW'(rsp_o.found_position),
                          ValW'(due.rsp.found_position));
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned counted;
    int unsigned run_len;
    bit          filling;
    req_t        cmd;

    // Directed rows: op, value, repeats, typed, status, removed, position.
    // Empty deque after reset: removals and search report empty.
    add_row(OP_REM_FRONT,   32'h1234_5678, 1, 1'b1, ST_EMPTY, '0, '0);
    add_row(OP_REM_REAR,    32'hFFFF_FFFF, 1, 1'b1, ST_EMPTY, '0, '0);
    add_row(OP_SEARCH,      32'h0000_0000, 1, 1'b1, ST_EMPTY, '0, '0);
    // Unused opcodes change nothing and answer ok with zero fields.
    add_row(OP_SPARE_FIRST, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,    '0, '0);
    add_row(OP_SPARE_LAST,  32'h8000_0000, 1, 1'b1, ST_OK,    '0, '0);
    // Extreme values at both ends; the front insert wraps the ring index.
    add_row(OP_INS_REAR,    32'h7FFF_FFFF, 1, 1'b1, ST_OK,    '0, '0);
    add_row(OP_INS_FRONT,   32'h8000_0000, 1, 1'b1, ST_OK,    '0, '0);
    add_row(OP_SEARCH,      32'h7FFF_FFFF, 1, 1'b1, ST_OK,    '0, 5'd2);
    add_row(OP_SEARCH,      32'h8000_0000, 1, 1'b1, ST_OK,    '0, 5'd1);
    add_row(OP_SEARCH,      32'h0000_0000, 1, 1'b1, ST_MISS,  '0, '0);
    add_row(OP_REM_REAR,    32'h0000_0000, 1, 1'b1, ST_OK,    32'h7FFF_FFFF, '0);
    add_row(OP_REM_FRONT,   32'h0000_0000, 1, 1'b1, ST_OK,    32'h8000_0000, '0);
    // Fill to capacity with duplicates behind one distinct front entry.
    add_row(OP_INS_FRONT,   32'h0000_0005, 1,  1'b0, ST_OK,   '0, '0);
    add_row(OP_INS_REAR,    32'hFFFF_FFFF, 15, 1'b0, ST_OK,   '0, '0);
    // Full deque refuses inserts at either end.
    add_row(OP_INS_REAR,    32'h0000_0001, 1, 1'b1, ST_FULL,  '0, '0);
    add_row(OP_INS_FRONT,   32'h0000_0001, 1, 1'b1, ST_FULL,  '0, '0);
    add_row(OP_SEARCH,      32'hFFFF_FFFF, 1, 1'b1, ST_OK,    '0, 5'd2);
    add_row(OP_SEARCH,      32'h0000_0005, 1, 1'b1, ST_OK,    '0, 5'd1);
    add_row(OP_SEARCH,      32'h0000_1234, 1, 1'b1, ST_MISS,  '0, '0);
    add_row(OP_REM_FRONT,   32'h0000_0000, 1, 1'b1, ST_OK,    32'h0000_0005, '0);
    // Refill the last slot and find it at the deepest position.
    add_row(OP_INS_REAR,    32'h0000_0009, 1, 1'b1, ST_OK,    '0, '0);
    add_row(OP_SEARCH,      32'h0000_0009, 1, 1'b1, ST_OK,    '0, 5'd16);
    add_row(OP_SPARE_MID,   32'h0000_0009, 1, 1'b1, ST_OK,    '0, '0);
    add_row(OP_REM_REAR,    32'h0000_0000, 1, 1'b1, ST_OK,    32'h0000_0009, '0);

    // Hold reset at the start, then release it once for the whole run.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows back to back.
    idle_pct = 0;
    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps) issue_cmd(stim_rows[i].cmd, stim_rows[i].typed,
                                           stim_rows[i].want);
    end
    drain_results();

    // Random traffic in phases of sender idling; each phase ends fully drained.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase == 1) ? 73 : (phase == 2) ? 33 : 0;
      counted  = 0;
      filling  = 1'b1;
      run_len  = $urandom_range(120, 40);
      while (counted < RANDOM_ITEMS / PHASES) begin
        // Swing between fill and drain runs so full and empty both recur.
        if (run_len == 0) begin
          filling = !filling;
          run_len = $urandom_range(120, 40);
        end
        run_len--;
        cmd = random_cmd(filling);
        issue_cmd(cmd, 1'b0, '0);
        if (cmd.opcode <= OP_SEARCH) counted++;
      end
      drain_results();
    end

    // Let any stray strobe show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** deque_with_search_core: PASSED **");
    end else begin
      $display("%0d mismatches", err_count);
      $display("** deque_with_search_core: FAILED **");
    end
    $finish;
  end

endmodule
